// ----- rtl/tmt_pkg.sv -----
package tmt_pkg;

  // Field and register widths
  localparam int IN_W    = 8;
  localparam int CNT_W   = 9;
  localparam int STEP_W  = 16;
  localparam int Q_W     = 16;
  localparam int IDX_W   = 16;
  localparam int POS_W   = 32;
  localparam int TEX_W   = 16;
  localparam int SIN_W   = 18;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Grid limits and sine resolution
  localparam int MAX_RINGS       = 256;
  localparam int MAX_DETAIL      = 256;
  localparam int SINE_TABLE_BITS = 10;

  // Quarter-wave polynomial coefficients
  localparam logic [16:0] SIN_CA = 17'd102944;
  localparam logic [15:0] SIN_CB = 16'd42047;
  localparam logic [12:0] SIN_CC = 13'd4639;

  // Pipeline depths
  localparam int SIN_LAT     = 5;
  localparam int DIV_STEPS   = 15;
  localparam int DIV_LAT     = DIV_STEPS + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register map
  typedef enum logic [2:0] {
    REG_RING_COUNT  = 3'd0,
    REG_RING_DETAIL = 3'd1,
    REG_RING_STEP   = 3'd2,
    REG_DETAIL_STEP = 3'd3,
    REG_MAJOR_RAD   = 3'd4,
    REG_TUBE_THICK  = 3'd5,
    REG_HALF_WIDTH  = 3'd6,
    REG_HALF_HEIGHT = 3'd7
  } tmt_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  ring_count;
    logic [CNT_W-1:0]  ring_detail;
    logic [STEP_W-1:0] ring_step;
    logic [STEP_W-1:0] detail_step;
    logic [Q_W-1:0]    radius;
    logic [Q_W-1:0]    thick;
    logic [Q_W-1:0]    hw;
    logic [Q_W-1:0]    hh;
  } tmt_cfg_t;

  // Per-cell data that rides beside the arithmetic
  typedef struct packed {
    logic             err;
    logic [IDX_W-1:0] here;
    logic [IDX_W-1:0] side;
    logic [IDX_W-1:0] diag;
    logic [IDX_W-1:0] below;
  } tmt_side_t;

  typedef struct packed {
    logic [STEP_W-1:0] tube_ph;
    logic [STEP_W-1:0] ring_ph;
    tmt_side_t         side;
  } tmt_cell_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [IDX_W-1:0] tri_first_a;
    logic [IDX_W-1:0] tri_first_b;
    logic [IDX_W-1:0] tri_first_c;
    logic [IDX_W-1:0] tri_second_b;
    logic [IDX_W-1:0] tri_second_c;
    logic             index_error;
  } tmt_res_t;

  localparam logic signed [39:0] POS_MAX40 = 40'sd2147483647;
  localparam logic signed [39:0] POS_MIN40 = -40'sd2147483648;

  // Clamp a wide signed value to 32 bits
  function automatic logic [POS_W-1:0] sat32(input logic signed [39:0] v);
    logic [POS_W-1:0] r;
    if (v > POS_MAX40) begin
      r = 32'h7FFF_FFFF;
    end else if (v < POS_MIN40) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/tmt_front.sv -----
module tmt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [tmt_pkg::IN_W-1:0] ring_index,
  input  logic [tmt_pkg::IN_W-1:0] detail_index,
  input  tmt_pkg::tmt_cfg_t     cfg,
  output logic                  push_valid,
  input  logic                  push_ready,
  output tmt_pkg::tmt_cell_t    push_cell
);
  import tmt_pkg::*;

  logic [CNT_W-1:0]   rc, dc, ri, di, rn, jn, ri_inc, di_inc;
  logic [2*CNT_W-1:0] prod_r, prod_rn;
  logic [31:0]        tube_full, ring_full;
  tmt_cell_t          cell_nxt, cell_r;
  logic               valid_r;

  // Clamp counts and classify the request
  always_comb begin
    rc = (32'(cfg.ring_count) > MAX_RINGS) ? CNT_W'(MAX_RINGS) : cfg.ring_count;
    dc = (32'(cfg.ring_detail) > MAX_DETAIL) ? CNT_W'(MAX_DETAIL) : cfg.ring_detail;
    ri = {1'b0, ring_index};
    di = {1'b0, detail_index};
    ri_inc = ri + CNT_W'(1);
    di_inc = di + CNT_W'(1);
    rn = (ri_inc >= rc) ? '0 : ri_inc;
    jn = (di_inc >= dc) ? '0 : di_inc;
    prod_r  = ri * dc;
    prod_rn = rn * dc;
    tube_full = 32'(detail_index) * 32'(cfg.detail_step);
    ring_full = 32'(ring_index) * 32'(cfg.ring_step);
    cell_nxt.tube_ph    = tube_full[STEP_W-1:0];
    cell_nxt.ring_ph    = ring_full[STEP_W-1:0];
    cell_nxt.side.err   = (ri >= rc) || (di >= dc);
    cell_nxt.side.here  = IDX_W'(prod_r + (2*CNT_W)'(di));
    cell_nxt.side.side  = IDX_W'(prod_r + (2*CNT_W)'(jn));
    cell_nxt.side.diag  = IDX_W'(prod_rn + (2*CNT_W)'(jn));
    cell_nxt.side.below = IDX_W'(prod_rn + (2*CNT_W)'(di));
  end

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_cell  = cell_r;

  // Hold the classified request until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

// ----- rtl/tmt_queue.sv -----
module tmt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  tmt_pkg::tmt_cell_t push_cell,
  output logic               pop_valid,
  input  logic               pop_ready,
  output tmt_pkg::tmt_cell_t pop_cell
);
  import tmt_pkg::*;

  tmt_cell_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cell   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cell;
    end
  end

endmodule

// ----- rtl/tmt_sine.sv -----
module tmt_sine (
  input  logic                            clk,
  input  logic                            en,
  input  logic [tmt_pkg::STEP_W-1:0]      phase,
  output logic signed [tmt_pkg::SIN_W-1:0] sine
);
  import tmt_pkg::*;

  localparam logic [15:0] KEEP = 16'(16'hFFFF << (16 - SINE_TABLE_BITS));

  logic [15:0] p, fr0;
  logic [16:0] f_nxt, f1_r, f2a_r, f3_r, f4_r, f2_r, f2b_r, t2_r, mag;
  logic [15:0] t1_r;
  logic        neg1_r, neg2_r, neg3_r, neg4_r;
  logic [33:0] m0, m3;
  logic [29:0] m1;
  logic [32:0] m2;
  logic signed [SIN_W-1:0] s_r;

  // Fold the phase into the first quarter
  always_comb begin
    p     = phase & KEEP;
    fr0   = {p[13:0], 2'b00};
    f_nxt = p[14] ? (17'd65536 - {1'b0, fr0}) : {1'b0, fr0};
    m0    = f1_r * f1_r;
    m1    = f2_r * SIN_CC;
    m2    = f2b_r * t1_r;
    m3    = f4_r * t2_r;
    mag   = (m3[33:16] > 18'd65536) ? 17'd65536 : m3[32:16];
  end

  // One product per stage of the polynomial
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= f_nxt;
      neg1_r <= p[15];
      f2_r   <= m0[32:16];
      f2a_r  <= f1_r;
      neg2_r <= neg1_r;
      t1_r   <= SIN_CB - 16'(m1[29:16]);
      f2b_r  <= f2_r;
      f3_r   <= f2a_r;
      neg3_r <= neg2_r;
      t2_r   <= SIN_CA - m2[32:16];
      f4_r   <= f3_r;
      neg4_r <= neg3_r;
      s_r    <= neg4_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sine = s_r;

endmodule

// ----- rtl/tmt_div.sv -----
module tmt_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [tmt_pkg::POS_W-1:0]        num,
  input  logic [tmt_pkg::Q_W-1:0]          den,
  output logic [tmt_pkg::TEX_W-1:0]        quot
);
  import tmt_pkg::*;

  localparam int REM_W = POS_W + 4;

  logic [REM_W-1:0]     rem_r  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_r    [DIV_STEPS+1];
  logic                 neg_r  [DIV_STEPS+1];
  logic                 sat_r  [DIV_STEPS+1];
  logic [POS_W:0]       mag;
  logic [TEX_W-1:0]     qext;

  // Take magnitude and detect overflow of the Q4.12 range
  always_comb begin
    mag = num[POS_W-1] ? -{1'b1, num} : {1'b0, num};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {mag[POS_W-1:0], 4'b0000};
      q_r[0]   <= '0;
      neg_r[0] <= num[POS_W-1];
      sat_r[0] <= mag >= (POS_W+1)'({den, 11'b0});
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int B = DIV_STEPS - 1 - i;
    logic [REM_W-1:0] dsh;
    logic             take;
    always_comb begin
      dsh  = REM_W'(den) << B;
      take = rem_r[i] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= take ? (rem_r[i] - dsh) : rem_r[i];
        q_r[i+1]    <= q_r[i] | (take ? DIV_STEPS'(1) << B : '0);
        neg_r[i+1]  <= neg_r[i];
        sat_r[i+1]  <= sat_r[i];
      end
    end
  end

  // Apply sign, saturation and the zero-divisor rule
  always_comb begin
    qext = {1'b0, q_r[DIV_STEPS]};
    if (den == '0) begin
      quot = '0;
    end else if (sat_r[DIV_STEPS]) begin
      quot = neg_r[DIV_STEPS] ? 16'h8000 : 16'h7FFF;
    end else begin
      quot = neg_r[DIV_STEPS] ? -qext : qext;
    end
  end

endmodule

// ----- rtl/tmt_back.sv -----
module tmt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cell_valid,
  output logic               cell_ready,
  input  tmt_pkg::tmt_cell_t cell_data,
  input  tmt_pkg::tmt_cfg_t  cfg,
  output logic               res_valid,
  input  logic               res_ready,
  output tmt_pkg::tmt_res_t  res
);
  import tmt_pkg::*;

  localparam int LAT    = SIN_LAT + 6 + DIV_LAT + 1;
  localparam int PY_DLY = DIV_LAT + 3;

  logic [LAT-1:0]          v_r;
  tmt_side_t               sd_r [LAT-1];
  logic [POS_W-1:0]        py_r [PY_DLY];
  logic [POS_W-1:0]        px_d_r [DIV_LAT];
  logic [POS_W-1:0]        pz_d_r [DIV_LAT];
  logic                    en;

  logic signed [SIN_W-1:0] st, ct, sp, cp;
  logic signed [SIN_W-1:0] sp_d_r [3];
  logic signed [SIN_W-1:0] cp_d_r [3];
  logic signed [SIN_W:0]   dif, sm;
  logic signed [Q_W:0]     thk, hws, hhs;
  logic signed [35:0]      m_arm_r, m_ht_r;
  logic signed [27:0]      arm_r, ht0_r;
  logic signed [44:0]      xr_full, ht_full;
  logic signed [36:0]      xr_r, ht_r;
  logic signed [18:0]      xl, xh;
  logic signed [36:0]      ppxl_r, ppxh_r, ppzl_r, ppzh_r;
  logic signed [54:0]      bx_r, bz_r;
  logic signed [55:0]      nbx;
  logic [POS_W-1:0]        px_r, pz_r;
  logic [TEX_W-1:0]        tu, tv;
  tmt_side_t               so;
  tmt_res_t                res_nxt, res_r;

  assign en         = !v_r[LAT-1] || res_ready;
  assign cell_ready = en;
  assign res_valid  = v_r[LAT-1];
  assign res        = res_r;

  // Advance the valid line with the whole pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], cell_valid};
    end
  end

  // Carry indices and error flag alongside
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= cell_data.side;
      for (int k = 1; k < LAT-1; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  tmt_sine u_st (.clk(clk), .en(en), .phase(cell_data.tube_ph), .sine(st));
  tmt_sine u_ct (.clk(clk), .en(en), .phase(cell_data.tube_ph + 16'd16384), .sine(ct));
  tmt_sine u_sp (.clk(clk), .en(en), .phase(cell_data.ring_ph), .sine(sp));
  tmt_sine u_cp (.clk(clk), .en(en), .phase(cell_data.ring_ph + 16'd16384), .sine(cp));

  always_comb begin
    dif = {ct[SIN_W-1], ct} - {st[SIN_W-1], st};
    sm  = {ct[SIN_W-1], ct} + {st[SIN_W-1], st};
    thk = $signed({1'b0, cfg.thick});
    hws = $signed({1'b0, cfg.hw});
    hhs = $signed({1'b0, cfg.hh});
    xr_full = arm_r * hws;
    ht_full = ht0_r * hhs;
    xl  = $signed({1'b0, xr_r[17:0]});
    xh  = xr_r[36:18];
    nbx = -{bx_r[54], bx_r};
  end

  // Tube offsets, arm, scaled radius, split products, sums, positions
  always_ff @(posedge clk) begin
    if (en) begin
      m_arm_r <= dif * thk;
      m_ht_r  <= sm * thk;
      sp_d_r[0] <= sp;
      cp_d_r[0] <= cp;
      for (int k = 1; k < 3; k++) begin
        sp_d_r[k] <= sp_d_r[k-1];
        cp_d_r[k] <= cp_d_r[k-1];
      end
      arm_r   <= $signed(m_arm_r[35:8]) + $signed({4'b0000, cfg.radius, 8'h00});
      ht0_r   <= $signed(m_ht_r[35:8]);
      xr_r    <= xr_full[44:8];
      ht_r    <= ht_full[44:8];
      ppxl_r  <= xl * sp_d_r[2];
      ppxh_r  <= xh * sp_d_r[2];
      ppzl_r  <= xl * cp_d_r[2];
      ppzh_r  <= xh * cp_d_r[2];
      bx_r    <= $signed({ppxh_r, 18'b0}) + 55'(ppxl_r);
      bz_r    <= $signed({ppzh_r, 18'b0}) + 55'(ppzl_r);
      px_r    <= sat32(nbx[55:16]);
      pz_r    <= sat32({bz_r[54], bz_r[54:16]});
      py_r[0] <= sat32({{3{ht_r[36]}}, ht_r});
      for (int k = 1; k < PY_DLY; k++) begin
        py_r[k] <= py_r[k-1];
      end
      px_d_r[0] <= px_r;
      pz_d_r[0] <= pz_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        px_d_r[k] <= px_d_r[k-1];
        pz_d_r[k] <= pz_d_r[k-1];
      end
    end
  end

  tmt_div u_du (.clk(clk), .en(en), .num(pz_r), .den(cfg.hh), .quot(tu));
  tmt_div u_dv (.clk(clk), .en(en), .num(px_r), .den(cfg.hw), .quot(tv));

  assign so = sd_r[LAT-2];

  // Drop everything but the flag for an out-of-range cell
  always_comb begin
    res_nxt             = '0;
    res_nxt.index_error = so.err;
    if (!so.err) begin
      res_nxt.pos_x        = px_d_r[DIV_LAT-1];
      res_nxt.pos_y        = py_r[PY_DLY-1];
      res_nxt.pos_z        = pz_d_r[DIV_LAT-1];
      res_nxt.tex_u        = tu;
      res_nxt.tex_v        = tv;
      res_nxt.tri_first_a  = so.here;
      res_nxt.tri_first_b  = so.side;
      res_nxt.tri_first_c  = so.diag;
      res_nxt.tri_second_b = so.diag;
      res_nxt.tri_second_c = so.below;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/torus_mesh_tessellator_unit.sv -----
// Channel   | Direction | Handshake             | Payload
// in        | input     | in_valid / in_ready   | ring and detail index of one cell
// out       | output    | out_valid / out_ready | position, texture, triangles, error
// cfg       | input     | APB psel/penable      | eight setup registers
//
// One cell accepted per clock while the output is not stalled; a result passes
// through the front register, two-entry queue and 28-stage back pipeline of sine
// polynomial, multiplies and two 15-step dividers.
// Reset is synchronous, clears the valid bits and loads the setup registers with defaults.
// A stalled output freezes the back pipeline; the queue and front register
// keep taking requests until they fill.
module torus_mesh_tessellator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmt_pkg::IN_W-1:0]      in_ring_index,
  input  logic [tmt_pkg::IN_W-1:0]      in_detail_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tmt_pkg::POS_W-1:0] out_pos_x,
  output logic signed [tmt_pkg::POS_W-1:0] out_pos_y,
  output logic signed [tmt_pkg::POS_W-1:0] out_pos_z,
  output logic signed [tmt_pkg::TEX_W-1:0] out_tex_u,
  output logic signed [tmt_pkg::TEX_W-1:0] out_tex_v,
  output logic [tmt_pkg::IDX_W-1:0]     out_tri_first_a,
  output logic [tmt_pkg::IDX_W-1:0]     out_tri_first_b,
  output logic [tmt_pkg::IDX_W-1:0]     out_tri_first_c,
  output logic [tmt_pkg::IDX_W-1:0]     out_tri_second_b,
  output logic [tmt_pkg::IDX_W-1:0]     out_tri_second_c,
  output logic                          out_index_error,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tmt_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [tmt_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [tmt_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import tmt_pkg::*;

  tmt_cfg_t  cfg_r;
  tmt_reg_t  reg_sel;
  logic      wr_en;
  logic      q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  tmt_cell_t q_push_cell, q_pop_cell;
  tmt_res_t  res;

  assign cfg_pready = 1'b1;
  assign reg_sel    = tmt_reg_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_count  <= CNT_W'(16);
      cfg_r.ring_detail <= CNT_W'(16);
      cfg_r.ring_step   <= STEP_W'(4096);
      cfg_r.detail_step <= STEP_W'(4096);
      cfg_r.radius      <= Q_W'(256);
      cfg_r.thick       <= Q_W'(64);
      cfg_r.hw          <= Q_W'(256);
      cfg_r.hh          <= Q_W'(256);
    end else if (wr_en) begin
      case (reg_sel)
        REG_RING_COUNT:  cfg_r.ring_count  <= cfg_pwdata[CNT_W-1:0];
        REG_RING_DETAIL: cfg_r.ring_detail <= cfg_pwdata[CNT_W-1:0];
        REG_RING_STEP:   cfg_r.ring_step   <= cfg_pwdata[STEP_W-1:0];
        REG_DETAIL_STEP: cfg_r.detail_step <= cfg_pwdata[STEP_W-1:0];
        REG_MAJOR_RAD:   cfg_r.radius      <= cfg_pwdata[Q_W-1:0];
        REG_TUBE_THICK:  cfg_r.thick       <= cfg_pwdata[Q_W-1:0];
        REG_HALF_WIDTH:  cfg_r.hw          <= cfg_pwdata[Q_W-1:0];
        REG_HALF_HEIGHT: cfg_r.hh          <= cfg_pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back setup registers
  always_comb begin
    case (reg_sel)
      REG_RING_COUNT:  cfg_prdata = DATA_W'(cfg_r.ring_count);
      REG_RING_DETAIL: cfg_prdata = DATA_W'(cfg_r.ring_detail);
      REG_RING_STEP:   cfg_prdata = DATA_W'(cfg_r.ring_step);
      REG_DETAIL_STEP: cfg_prdata = DATA_W'(cfg_r.detail_step);
      REG_MAJOR_RAD:   cfg_prdata = DATA_W'(cfg_r.radius);
      REG_TUBE_THICK:  cfg_prdata = DATA_W'(cfg_r.thick);
      REG_HALF_WIDTH:  cfg_prdata = DATA_W'(cfg_r.hw);
      REG_HALF_HEIGHT: cfg_prdata = DATA_W'(cfg_r.hh);
      default:         cfg_prdata = '0;
    endcase
  end

  tmt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ring_index   (in_ring_index),
    .detail_index (in_detail_index),
    .cfg          (cfg_r),
    .push_valid   (q_push_valid),
    .push_ready   (q_push_ready),
    .push_cell    (q_push_cell)
  );

  tmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cell  (q_push_cell),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cell   (q_pop_cell)
  );

  tmt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (q_pop_valid),
    .cell_ready (q_pop_ready),
    .cell_data  (q_pop_cell),
    .cfg        (cfg_r),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_pos_x        = $signed(res.pos_x);
  assign out_pos_y        = $signed(res.pos_y);
  assign out_pos_z        = $signed(res.pos_z);
  assign out_tex_u        = $signed(res.tex_u);
  assign out_tex_v        = $signed(res.tex_v);
  assign out_tri_first_a  = res.tri_first_a;
  assign out_tri_first_b  = res.tri_first_b;
  assign out_tri_first_c  = res.tri_first_c;
  assign out_tri_second_b = res.tri_second_b;
  assign out_tri_second_c = res.tri_second_c;
  assign out_index_error  = res.index_error;

endmodule

// ----- rtl/tmt_checker.sv -----
module tmt_sva (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [tmt_pkg::POS_W-1:0] out_pos_x,
  input logic signed [tmt_pkg::POS_W-1:0] out_pos_y,
  input logic signed [tmt_pkg::TEX_W-1:0] out_tex_u,
  input logic [tmt_pkg::IDX_W-1:0]     out_tri_first_a,
  input logic [tmt_pkg::IDX_W-1:0]     out_tri_first_c,
  input logic [tmt_pkg::IDX_W-1:0]     out_tri_second_b,
  input logic                          out_index_error
);
  import tmt_pkg::*;

  // A stalled result stays valid and keeps its x position and first vertex index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_tri_first_a))
    else $error("result changed while stalled");

  // Out-of-range cells carry no geometry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |->
      out_pos_x == '0 && out_pos_y == '0 && out_tex_u == '0 && out_tri_first_a == '0)
    else $error("geometry on an out-of-range cell");

  // Both triangles share the diagonal vertex
  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_error |-> out_tri_first_c == out_tri_second_b)
    else $error("triangles do not share the diagonal");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind torus_mesh_tessellator_unit tmt_sva u_tmt_sva (.*);

// ----- dv/tmt_checker.sv -----
module tmt_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [tmt_pkg::IN_W-1:0]      in_ring_index,
  input  logic [tmt_pkg::IN_W-1:0]      in_detail_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tmt_pkg::POS_W-1:0]     out_pos_x,
  input  logic [tmt_pkg::POS_W-1:0]     out_pos_y,
  input  logic [tmt_pkg::POS_W-1:0]     out_pos_z,
  input  logic [tmt_pkg::TEX_W-1:0]     out_tex_u,
  input  logic [tmt_pkg::TEX_W-1:0]     out_tex_v,
  input  logic [tmt_pkg::IDX_W-1:0]     out_tri_first_a,
  input  logic [tmt_pkg::IDX_W-1:0]     out_tri_first_b,
  input  logic [tmt_pkg::IDX_W-1:0]     out_tri_first_c,
  input  logic [tmt_pkg::IDX_W-1:0]     out_tri_second_b,
  input  logic [tmt_pkg::IDX_W-1:0]     out_tri_second_c,
  input  logic                          out_index_error,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [tmt_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [tmt_pkg::DATA_W-1:0]    cfg_pwdata,
  output int                            mismatch_count,
  output int                            cells_pending,
  output int                            cells_returned
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmt_pkg::*;

  tmt_cfg_t shadow_cfg;
  tmt_res_t expected_cells[$];

  // Quarter-wave polynomial, Q16 in and out
  function automatic longint quarter_wave(longint unsigned f);
    longint unsigned f2;
    longint unsigned t;
    f2 = (f * f) >> 16;
    t = 42047 - ((f2 * 4639) >> 16);
    t = 102944 - ((f2 * t) >> 16);
    t = (f * t) >> 16;
    if (t > 65536) t = 65536;
    return longint'(t);
  endfunction

  function automatic longint sine_of(logic [15:0] phase);
    logic [15:0] p;
    logic [1:0] quad;
    longint unsigned fr;
    longint s;
    p = phase & 16'hFFC0;
    quad = p[15:14];
    fr = longint'(p[13:0]) << 2;
    if (quad[0]) fr = 65536 - fr;
    s = quarter_wave(fr);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint tex_ratio(longint num, logic [15:0] den);
    if (den == 0) return 0;
    return clamp((num * 16) / longint'(den), -32768, 32767);
  endfunction

  // Vertex, texture and triangle indices for one grid cell
  function automatic tmt_res_t cell_geometry(logic [7:0] ri, logic [7:0] di);
    tmt_res_t res;
    int unsigned rc, dc, rn, jn;
    logic [15:0] tube_ph, ring_ph;
    longint st, ct, sp, cp, arm, xr, ht, px, py, pz, tu, tv;
    res = '0;
    rc = (shadow_cfg.ring_count > MAX_RINGS) ? MAX_RINGS : shadow_cfg.ring_count;
    dc = (shadow_cfg.ring_detail > MAX_DETAIL) ? MAX_DETAIL : shadow_cfg.ring_detail;
    if (ri >= rc || di >= dc) begin
      res.index_error = 1'b1;
      return res;
    end
    tube_ph = di * shadow_cfg.detail_step;
    ring_ph = ri * shadow_cfg.ring_step;
    st = sine_of(tube_ph);
    ct = sine_of(tube_ph + 16'd16384);
    sp = sine_of(ring_ph);
    cp = sine_of(ring_ph + 16'd16384);
    arm = (longint'(shadow_cfg.radius) << 8) + (((ct - st) * longint'(shadow_cfg.thick)) >>> 8);
    xr = (arm * longint'(shadow_cfg.hw)) >>> 8;
    ht = ((((st + ct) * longint'(shadow_cfg.thick)) >>> 8) * longint'(shadow_cfg.hh)) >>> 8;
    px = clamp((-xr * sp) >>> 16, -64'sd2147483648, 64'sd2147483647);
    py = clamp(ht, -64'sd2147483648, 64'sd2147483647);
    pz = clamp((xr * cp) >>> 16, -64'sd2147483648, 64'sd2147483647);
    tu = tex_ratio(pz, shadow_cfg.hh);
    tv = tex_ratio(px, shadow_cfg.hw);
    rn = (ri + 1 >= rc) ? 0 : ri + 1;
    jn = (di + 1 >= dc) ? 0 : di + 1;
    res.pos_x = px[31:0];
    res.pos_y = py[31:0];
    res.pos_z = pz[31:0];
    res.tex_u = tu[15:0];
    res.tex_v = tv[15:0];
    res.tri_first_a = 16'(ri * dc + di);
    res.tri_first_b = 16'(ri * dc + jn);
    res.tri_first_c = 16'(rn * dc + jn);
    res.tri_second_b = 16'(rn * dc + jn);
    res.tri_second_c = 16'(rn * dc + di);
    return res;
  endfunction

  always @(posedge clk) begin
    tmt_res_t got, want;
    if (!rst_n) begin
      shadow_cfg <= '{ring_count: 9'd16, ring_detail: 9'd16, ring_step: 16'd4096,
                      detail_step: 16'd4096, radius: 16'd256, thick: 16'd64,
                      hw: 16'd256, hh: 16'd256};
      expected_cells.delete();
      mismatch_count <= 0;
      cells_returned <= 0;
      cells_pending <= 0;
    end else begin
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (tmt_reg_t'(cfg_paddr[4:2]))
          REG_RING_COUNT:  shadow_cfg.ring_count  <= cfg_pwdata[8:0];
          REG_RING_DETAIL: shadow_cfg.ring_detail <= cfg_pwdata[8:0];
          REG_RING_STEP:   shadow_cfg.ring_step   <= cfg_pwdata[15:0];
          REG_DETAIL_STEP: shadow_cfg.detail_step <= cfg_pwdata[15:0];
          REG_MAJOR_RAD:   shadow_cfg.radius      <= cfg_pwdata[15:0];
          REG_TUBE_THICK:  shadow_cfg.thick       <= cfg_pwdata[15:0];
          REG_HALF_WIDTH:  shadow_cfg.hw          <= cfg_pwdata[15:0];
          REG_HALF_HEIGHT: shadow_cfg.hh          <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      // Predict each accepted request
      if (in_valid && in_ready)
        expected_cells.insert(expected_cells.size(),
                              cell_geometry(in_ring_index, in_detail_index));
      // Compare each returned cell with the oldest prediction
      if (out_valid && out_ready) begin
        cells_returned <= cells_returned + 1;
        got = '{out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                out_tri_first_a, out_tri_first_b, out_tri_first_c,
                out_tri_second_b, out_tri_second_c, out_index_error};
        if (expected_cells.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result %p", got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("mismatch: expected %p actual %p", want, got);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      cells_pending <= expected_cells.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tmt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] in_ring_index = '0;
  logic [IN_W-1:0] in_detail_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [TEX_W-1:0] out_tex_u, out_tex_v;
  logic [IDX_W-1:0] out_tri_first_a, out_tri_first_b, out_tri_first_c;
  logic [IDX_W-1:0] out_tri_second_b, out_tri_second_c;
  logic out_index_error;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  int mismatch_count, cells_pending, cells_returned;
  bit no_gaps = 1'b0;
  bit holdoff_done = 1'b0;
  int stall_cycles = 0;
  int unsigned ring_limit = 16, detail_limit = 16;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  torus_mesh_tessellator_unit u_dut (.*);

  tmt_checker u_checker (.*);

  // Write one register through the APB port
  task automatic write_reg(tmt_reg_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = ADDR_W'(idx) << 2;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (idx == REG_RING_COUNT) ring_limit = value[8:0] > 256 ? 256 : value[8:0];
    if (idx == REG_RING_DETAIL) detail_limit = value[8:0] > 256 ? 256 : value[8:0];
  endtask

  // Offer one cell request and hold it until accepted
  task automatic send_cell(logic [7:0] ri, logic [7:0] di);
    while (!no_gaps && $urandom_range(99) < 37) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_ring_index = ri;
    in_detail_index = di;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Mostly legal cells, some random ones to hit the error flag
  task automatic send_random_cells(int count);
    logic [7:0] ri, di;
    repeat (count) begin
      if ($urandom_range(99) < 85 && ring_limit > 0 && detail_limit > 0) begin
        ri = 8'($urandom_range(ring_limit - 1));
        di = 8'($urandom_range(detail_limit - 1));
      end else begin
        ri = 8'($urandom_range(255));
        di = 8'($urandom_range(255));
      end
      send_cell(ri, di);
    end
  endtask

  // Drain the block before touching registers
  task automatic settle();
    in_valid = 1'b0;
    while (cells_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_setup();
    write_reg(REG_RING_COUNT, $urandom_range(99) < 85 ? $urandom_range(1, 256)
                                                      : $urandom_range(511));
    write_reg(REG_RING_DETAIL, $urandom_range(99) < 85 ? $urandom_range(1, 256)
                                                       : $urandom_range(511));
    write_reg(REG_RING_STEP, $urandom_range(65535));
    write_reg(REG_DETAIL_STEP, $urandom_range(65535));
    write_reg(REG_MAJOR_RAD, $urandom_range(99) < 50 ? $urandom_range(2047)
                                                     : $urandom_range(65535));
    write_reg(REG_TUBE_THICK, $urandom_range(99) < 50 ? $urandom_range(1023)
                                                      : $urandom_range(65535));
    write_reg(REG_HALF_WIDTH, $urandom_range(99) < 10 ? 0 : $urandom_range(65535));
    write_reg(REG_HALF_HEIGHT, $urandom_range(99) < 10 ? 0 : $urandom_range(65535));
  endtask

  // Result side: random stalls, one long hold-off while requests keep coming
  initial begin
    forever begin
      @(negedge clk);
      if (!holdoff_done && cells_returned >= 200) begin
        out_ready = 1'b0;
        repeat (150) @(negedge clk);
        holdoff_done = 1'b1;
      end else begin
        out_ready = no_gaps || ($urandom_range(99) >= 37);
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset setup: corners, next-ring and next-column wrap, out of range
    send_cell(0, 0);
    send_cell(15, 15);
    send_cell(15, 0);
    send_cell(0, 15);
    send_cell(7, 3);
    send_cell(16, 0);
    send_cell(0, 16);
    send_cell(255, 255);
    settle();

    // Largest sizes and steps, saturating positions
    write_reg(REG_RING_COUNT, 256);
    write_reg(REG_RING_DETAIL, 256);
    write_reg(REG_RING_STEP, 65535);
    write_reg(REG_DETAIL_STEP, 65535);
    write_reg(REG_MAJOR_RAD, 65535);
    write_reg(REG_TUBE_THICK, 65535);
    write_reg(REG_HALF_WIDTH, 65535);
    write_reg(REG_HALF_HEIGHT, 65535);
    send_cell(255, 255);
    send_cell(0, 0);
    send_cell(128, 77);
    send_cell(64, 192);
    settle();

    // Counts above the limit, zero steps and zero divisors
    write_reg(REG_RING_COUNT, 511);
    write_reg(REG_RING_DETAIL, 300);
    write_reg(REG_RING_STEP, 0);
    write_reg(REG_DETAIL_STEP, 0);
    write_reg(REG_MAJOR_RAD, 0);
    write_reg(REG_HALF_WIDTH, 0);
    write_reg(REG_HALF_HEIGHT, 0);
    send_cell(255, 255);
    send_cell(3, 9);
    settle();

    // Zero counts flag every cell
    write_reg(REG_RING_COUNT, 0);
    write_reg(REG_RING_DETAIL, 0);
    send_cell(0, 0);
    send_cell(1, 1);
    settle();
    write_reg(REG_RING_COUNT, 1);
    write_reg(REG_RING_DETAIL, 1);
    send_cell(0, 0);
    send_cell(0, 1);
    settle();

    // Random setups; the second phase runs with no gaps to fill the block
    for (int phase = 0; phase < 8; phase++) begin
      random_setup();
      no_gaps = (phase == 1);
      send_random_cells(115);
      no_gaps = 1'b0;
      settle();
    end

    if (mismatch_count == 0 && cells_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
